[rtl/core/cbd_pkg.sv]
// shared types, constants and helpers for the chunked body decoder
// no dependencies

package cbd_pkg;

   localparam int SIZE_BITS = 32;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam int         HEX_BITS = 4;   // one digit of radix 16

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [8:0] {
      PH_SIZE     = 9'b000000001,
      PH_SIZE_LF  = 9'b000000010,
      PH_DATA     = 9'b000000100,
      PH_DATA_CR  = 9'b000001000,
      PH_DATA_LF  = 9'b000010000,
      PH_FINAL_CR = 9'b000100000,
      PH_FINAL_LF = 9'b001000000,
      PH_DONE     = 9'b010000000,
      PH_STOPPED  = 9'b100000000
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
   } result_type;

   typedef struct packed {
      logic                is_hex;
      logic [HEX_BITS-1:0] digit;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type    h;
      logic [7:0] t;
      h = '0;
      t = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         t = b - 8'h30;
         h.is_hex = 1'b1;
      end else if (b >= 8'h61 && b <= 8'h66) begin
         t = b - 8'h57;
         h.is_hex = 1'b1;
      end else if (b >= 8'h41 && b <= 8'h46) begin
         t = b - 8'h37;
         h.is_hex = 1'b1;
      end
      h.digit = t[HEX_BITS-1:0];
      return h;
   endfunction

endpackage

[rtl/core/chunked_body_decoder_unit.sv]
// chunked body decoder top level: framing state machine and result skid buffer
// depends on cbd_pkg

// Decodes an HTTP/1.1 chunked body, one byte per item on the req_ channel.
// Each chunk is a hex size line ended by CR LF, then that many payload bytes,
// then CR LF. A zero size line followed by CR LF and an empty trailer line
// (CR LF) ends the body.
// rsp_ channel: one item per payload byte (kind data), one item at the end
// of the body (kind end) or one item on any framing fault (kind error).
// Size line bytes and CR/LF bytes give no item.
// Throughput: one input item per clock while req_stall is low; the framing
// state is updated in the cycle the byte is taken.
// Unless rsp_ stalls, a result shows on rsp_ the cycle after its byte is taken.
// The output register is backed by a one-entry skid stage, so a stall on
// rsp_ only stops the input side once the skid stage is also full; req_stall
// is driven straight from that stage's valid flag.
// After an error the block stops and ignores all bytes until reset; after
// the end of the body all bytes are ignored with no result.
// Reset (synchronous, active high) returns to reading a size line with an
// empty output register and skid stage.

module chunked_body_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte
);
   import cbd_pkg::*;

   // framing state
   phase_type            phase_ff, phase_in;
   logic [SIZE_BITS-1:0] chunk_size_ff, chunk_size_in;
   logic [SIZE_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic                 size_seen_ff, size_seen_in;

   // output register and skid stage
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   // result of the byte taken this cycle
   logic       res_valid;
   result_type res;

   logic                 accept;
   hex_type              hex;
   logic [SIZE_BITS-1:0] left_dec;
   logic                 out_free;

   assign accept   = req_valid && !req_stall;
   assign hex      = hex_decode(req_in_byte);
   assign left_dec = bytes_left_ff - SIZE_BITS'(1);

   // ---------------------------------------------------------------
   // framing state machine, one byte per cycle while req_stall is low
   // ---------------------------------------------------------------
   always_comb begin
      phase_in      = phase_ff;
      chunk_size_in = chunk_size_ff;
      bytes_left_in = bytes_left_ff;
      size_seen_in  = size_seen_ff;
      res_valid     = 1'b0;
      res           = '{kind: KIND_DATA, out_byte: 8'h00};

      if (accept) begin
         unique case (phase_ff)
            PH_SIZE: begin
               if (req_in_byte == CH_CR) begin
                  if (!size_seen_ff) begin
                     // empty size line
                     phase_in  = PH_STOPPED;
                     res_valid = 1'b1;
                     res.kind  = KIND_ERR;
                  end else begin
                     phase_in = PH_SIZE_LF;
                  end
               end else if (!hex.is_hex ||
                            chunk_size_ff[SIZE_BITS-1 -: HEX_BITS] != '0) begin
                  // bad size character, or the next digit would overflow
                  phase_in  = PH_STOPPED;
                  res_valid = 1'b1;
                  res.kind  = KIND_ERR;
               end else begin
                  chunk_size_in = {chunk_size_ff[SIZE_BITS-HEX_BITS-1:0], hex.digit};
                  size_seen_in  = 1'b1;
               end
            end
            PH_SIZE_LF: begin
               if (req_in_byte != CH_LF) begin
                  phase_in  = PH_STOPPED;
                  res_valid = 1'b1;
                  res.kind  = KIND_ERR;
               end else if (chunk_size_ff == '0) begin
                  // last chunk, expect the empty trailer line
                  phase_in = PH_FINAL_CR;
               end else begin
                  bytes_left_in = chunk_size_ff;
                  phase_in      = PH_DATA;
               end
            end
            PH_DATA: begin
               bytes_left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = PH_DATA_CR;
               end
               res_valid    = 1'b1;
               res.kind     = KIND_DATA;
               res.out_byte = req_in_byte;
            end
            PH_DATA_CR: begin
               if (req_in_byte != CH_CR) begin
                  phase_in  = PH_STOPPED;
                  res_valid = 1'b1;
                  res.kind  = KIND_ERR;
               end else begin
                  phase_in = PH_DATA_LF;
               end
            end
            PH_DATA_LF: begin
               if (req_in_byte != CH_LF) begin
                  phase_in  = PH_STOPPED;
                  res_valid = 1'b1;
                  res.kind  = KIND_ERR;
               end else begin
                  chunk_size_in = '0;
                  size_seen_in  = 1'b0;
                  phase_in      = PH_SIZE;
               end
            end
            PH_FINAL_CR: begin
               if (req_in_byte != CH_CR) begin
                  phase_in  = PH_STOPPED;
                  res_valid = 1'b1;
                  res.kind  = KIND_ERR;
               end else begin
                  phase_in = PH_FINAL_LF;
               end
            end
            PH_FINAL_LF: begin
               res_valid = 1'b1;
               if (req_in_byte != CH_LF) begin
                  phase_in = PH_STOPPED;
                  res.kind = KIND_ERR;
               end else begin
                  phase_in = PH_DONE;
                  res.kind = KIND_END;
               end
            end
            default: begin
               // done or stopped: bytes are swallowed
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // output register with one-entry skid stage
   // ---------------------------------------------------------------
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // no byte is taken while the skid stage is full
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_in       = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         chunk_size_ff <= '0;
         bytes_left_ff <= '0;
         size_seen_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         chunk_size_ff <= chunk_size_in;
         bytes_left_ff <= bytes_left_in;
         size_seen_ff  <= size_seen_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall    = skid_valid_ff;
   assign rsp_valid    = out_valid_ff;
   assign rsp_kind     = out_ff.kind;
   assign rsp_out_byte = out_ff.out_byte;

endmodule

[rtl/core/cbd_checker.sv]
// port-level checks for the chunked body decoder, bound to the top level
// depends on cbd_pkg and chunked_body_decoder_unit

module cbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_byte
);
   import cbd_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte))
      else $error("stalled result changed");

   // only the three defined kinds, and non-data items carry a zero byte
   a_kind_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_DATA || rsp_kind == KIND_END || rsp_kind == KIND_ERR))
      else $error("bad result kind");

   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_DATA |-> rsp_out_byte == 8'h00)
      else $error("end or error item with nonzero byte");

   // end and error are the last item: rsp_valid drops once either is taken
   a_last_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind != KIND_DATA |=> !rsp_valid)
      else $error("item after end or error");

   // nothing pending straight after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

endmodule

bind chunked_body_decoder_unit cbd_checker u_cbd_checker (.*);

[tb/sv/chunked_body_decoder_unit_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for chunked_body_decoder_unit: streams chunked bodies one byte
// per item and checks every rsp_ item against a behavioural model of the framing rules
// depends on cbd_pkg and the decoder rtl

module chunked_body_decoder_unit_tb;
   import cbd_pkg::*;

   // the one way this run's body finishes: a clean end or one framing fault,
   // since the decoder stays stopped after either and reset is never repeated
   typedef enum int {
      END_CLEAN,
      END_EMPTY_SIZE,
      END_BAD_SIZE_BYTE,
      END_SIZE_OVERFLOW,
      END_NO_SIZE_LF,
      END_NO_DATA_CR,
      END_NO_DATA_LF,
      END_NO_FINAL_CR,
      END_NO_FINAL_LF
   } ending_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;

   // idling percentages, changed per phase
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int bytes_sent = 0;
   int mismatch_count = 0;

   // framing model state, starts as after reset
   phase_type            frame_phase = PH_SIZE;
   logic [SIZE_BITS-1:0] size_acc = '0;
   logic [SIZE_BITS-1:0] payload_left = '0;
   logic                 digit_seen = 1'b0;
   // rsp_ items still owed by the decoder, oldest first
   result_type           due_results[$];

   chunked_body_decoder_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bit 4 flags a hex character, bits 3:0 hold its value
   function automatic logic [4:0] hex_lookup(input logic [7:0] b);
      if (b >= "0" && b <= "9") return {1'b1, 4'(b - "0")};
      if (b >= "a" && b <= "f") return {1'b1, 4'(b - "a" + 8'd10)};
      if (b >= "A" && b <= "F") return {1'b1, 4'(b - "A" + 8'd10)};
      return 5'b0;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 4'd10) return "0" + n;
      return (upper ? "A" : "a") + n - 8'd10;
   endfunction

   function automatic logic [7:0] any_byte_but(input logic [7:0] avoid);
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == avoid);
      return b;
   endfunction

   // model of one accepted byte: updates the framing state and queues
   // the rsp_ item that the byte gives, if any
   task automatic track_framing(input logic [7:0] b);
      logic [4:0] hex;
      result_type res;
      bit         gives;
      hex = hex_lookup(b);
      res.kind = KIND_ERR;
      res.out_byte = 8'h00;
      gives = 1'b0;
      case (frame_phase)
         PH_SIZE: begin
            if (b == CH_CR && digit_seen) begin
               frame_phase = PH_SIZE_LF;
            // empty size, non-hex byte, or a digit that would not fit
            end else if (b == CH_CR || !hex[4] || size_acc[SIZE_BITS-1 -: HEX_BITS] != '0) begin
               gives = 1'b1;
            end else begin
               size_acc = {size_acc[SIZE_BITS-HEX_BITS-1:0], hex[HEX_BITS-1:0]};
               digit_seen = 1'b1;
            end
         end
         PH_SIZE_LF: begin
            if (b != CH_LF) begin
               gives = 1'b1;
            end else if (size_acc == '0) begin
               frame_phase = PH_FINAL_CR;
            end else begin
               payload_left = size_acc;
               frame_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            // payload bytes pass through whatever their value, CR and LF too
            payload_left = payload_left - 1'b1;
            if (payload_left == '0) frame_phase = PH_DATA_CR;
            res.kind = KIND_DATA;
            res.out_byte = b;
            gives = 1'b1;
         end
         PH_DATA_CR: begin
            if (b != CH_CR) gives = 1'b1;
            else frame_phase = PH_DATA_LF;
         end
         PH_DATA_LF: begin
            if (b != CH_LF) begin
               gives = 1'b1;
            end else begin
               size_acc = '0;
               digit_seen = 1'b0;
               frame_phase = PH_SIZE;
            end
         end
         PH_FINAL_CR: begin
            if (b != CH_CR) gives = 1'b1;
            else frame_phase = PH_FINAL_LF;
         end
         PH_FINAL_LF: begin
            if (b != CH_LF) begin
               gives = 1'b1;
            end else begin
               frame_phase = PH_DONE;
               res.kind = KIND_END;
               gives = 1'b1;
            end
         end
         // done or stopped: the byte is swallowed
         default: ;
      endcase
      // an error item leaves the decoder stopped for good
      if (gives && res.kind == KIND_ERR) frame_phase = PH_STOPPED;
      if (gives) due_results.insert(due_results.size(), res);
   endtask

   // one item on req_: random idle cycles first, then hold until taken;
   // valid stays high afterwards so back-to-back items need no gap
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      track_framing(b);
      bytes_sent++;
   endtask

   // hex size line with pad leading zeros and mixed letter case, then CR LF
   task automatic send_size_line(input logic [SIZE_BITS-1:0] value, input int pad);
      int ndig;
      int i;
      ndig = 1;
      while (ndig < SIZE_BITS / HEX_BITS && (value >> (ndig * HEX_BITS)) != 0) ndig++;
      repeat (pad) send_byte("0");
      for (i = ndig - 1; i >= 0; i--) begin
         send_byte(hex_char(value[i*HEX_BITS +: HEX_BITS], 1'($urandom_range(1))));
      end
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   task automatic send_payload(input int len);
      repeat (len) send_byte(8'($urandom_range(255)));
   endtask

   task automatic send_chunk(input int len);
      send_size_line(len, $urandom_range(3));
      send_payload(len);
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   // sender drops valid and waits for every owed item to come out
   task automatic wait_for_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // short chunks with leading zeros and payload extremes, CR and LF as data
   task automatic test_directed_framing;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_size_line(1, 4);
      send_byte(8'h00);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_size_line(2, 0);
      send_byte(8'hFF);
      send_byte(CH_CR);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_size_line(1, 2);
      send_byte(CH_LF);
      send_byte(CH_CR);
      send_byte(CH_LF);
      wait_for_results();
   endtask

   // well-formed chunks with random sizes and content; mostly short,
   // now and then 64 to 300 bytes
   task automatic test_random_chunks(input int count, input int idle_pct, input int stall_pct);
      int start;
      start = bytes_sent;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      while (bytes_sent - start < count) begin
         if ($urandom_range(19) == 0) send_chunk($urandom_range(300, 64));
         else send_chunk($urandom_range(40, 1));
      end
      // full pause of the sender until the decoder has caught up
      wait_for_results();
   endtask

   // finishes the body one way chosen at random, then trailing bytes
   // that the decoder must swallow without any item
   task automatic test_stream_ending;
      ending_type ending;
      logic [7:0] b;
      int         len;
      ending = ending_type'($urandom_range(END_NO_FINAL_LF, END_CLEAN));
      len = $urandom_range(12, 1);
      sender_idle_pct = 30;
      receiver_stall_pct = 30;
      case (ending)
         END_CLEAN: send_size_line(0, $urandom_range(3));
         END_EMPTY_SIZE: send_byte(CH_CR);
         END_BAD_SIZE_BYTE: begin
            repeat ($urandom_range(2))
               send_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            do b = 8'($urandom_range(255)); while (hex_lookup(b) != 5'b0 || b == CH_CR);
            send_byte(b);
         end
         END_SIZE_OVERFLOW: begin
            // a leading 1 and eight more digits: the last one cannot fit
            repeat ($urandom_range(3)) send_byte("0");
            send_byte("1");
            repeat (8) send_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
         end
         END_NO_SIZE_LF: begin
            send_byte(hex_char(4'(len), 1'($urandom_range(1))));
            send_byte(CH_CR);
            send_byte(any_byte_but(CH_LF));
         end
         END_NO_DATA_CR: begin
            send_size_line(len, 0);
            send_payload(len);
            send_byte(any_byte_but(CH_CR));
         end
         END_NO_DATA_LF: begin
            send_size_line(len, 0);
            send_payload(len);
            send_byte(CH_CR);
            send_byte(any_byte_but(CH_LF));
         end
         END_NO_FINAL_CR: begin
            send_size_line(0, 0);
            send_byte(any_byte_but(CH_CR));
         end
         END_NO_FINAL_LF: begin
            send_size_line(0, 0);
            send_byte(CH_CR);
            send_byte(any_byte_but(CH_LF));
         end
         default: ;
      endcase
      // a clean end needs its empty trailer line
      if (ending == END_CLEAN) begin
         send_byte(CH_CR);
         send_byte(CH_LF);
      end
      repeat ($urandom_range(30, 5)) send_byte(8'($urandom_range(255)));
   endtask

   // receiver side: random stall, changed on the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // every item taken on rsp_ is checked against the oldest owed one
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("rsp item with none due: kind %0d, out_byte %0h", rsp_kind, rsp_out_byte);
            mismatch_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               mismatch_count++;
            end
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_out_byte);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      // reset held from time zero, released on a falling edge
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_directed_framing();
      // idling phases: none, sender only, receiver only, both
      test_random_chunks(350, 0, 0);
      test_random_chunks(350, 59, 0);
      test_random_chunks(350, 0, 59);
      test_random_chunks(350, 30, 30);
      test_stream_ending();
      wait_for_results();
      // quiet tail: any stray item would show up here
      receiver_stall_pct = 0;
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("chunked_body_decoder_unit: match");
      end else begin
         $display("chunked_body_decoder_unit: mismatch");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("chunked_body_decoder_unit: mismatch");
      $finish;
   end

endmodule

[chunked_body_decoder_unit.f]
rtl/core/cbd_pkg.sv
rtl/core/chunked_body_decoder_unit.sv
rtl/core/cbd_checker.sv
tb/sv/chunked_body_decoder_unit_tb.sv
